### design/ohb_pkg.sv
// ----------------------------------------------------------------------------
// ohb_pkg
// Shared types, constants and small helper functions of the bar resampler.
// ----------------------------------------------------------------------------
package ohb_pkg;

  // Default price width, fixed point in units of 1/10000
  localparam int PRICE_BITS_DEF = 32;

  // Time stamp fields
  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;

  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
  } stamp_t;

  // Volume of one minute and of a running bar
  localparam int VOL_IN_W = 40;
  localparam int VOL_W    = 48;
  typedef logic [VOL_IN_W-1:0] vol_in_t;
  typedef logic [VOL_W-1:0]    vol_t;

  // Width of one packed result word: stamp, four prices, volume, last flag
  function automatic int res_w(input int price_bits);
    return $bits(stamp_t) + 4 * price_bits + VOL_W + 1;
  endfunction

  // Bar interval codes
  localparam logic [2:0] MODE_PASS = 3'd2;
  localparam logic [2:0] MODE_1H   = 3'd3;
  localparam logic [2:0] MODE_2H   = 3'd4;
  localparam logic [2:0] MODE_4H   = 3'd5;
  localparam logic [2:0] MODE_DAY  = 3'd6;

  // Calendar constants and hour spans
  localparam int HOURS_PER_DAY = 24;
  localparam int DAYS_PER_WEEK = 7;
  localparam logic [4:0] SPAN_2H = 5'd2;
  localparam logic [4:0] SPAN_4H = 5'd4;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_BAR_INTERVAL = 1'b0;

  // Result queue depth (power of two, at least 2)
  localparam int FIFO_DEPTH = 4;

  // Push strobes from the engine into the result queue
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  // (a - b) mod 24, non-negative; a, b < 32
  function automatic hour_t hour_gap(input hour_t a, input hour_t b);
    logic [6:0] x;
    x = 7'(a) + 7'(2 * HOURS_PER_DAY) - 7'(b);
    if (x >= 7'(2 * HOURS_PER_DAY + HOURS_PER_DAY)) begin
      x = x - 7'(3 * HOURS_PER_DAY);
    end else if (x >= 7'(2 * HOURS_PER_DAY)) begin
      x = x - 7'(2 * HOURS_PER_DAY);
    end else if (x >= 7'(HOURS_PER_DAY)) begin
      x = x - 7'(HOURS_PER_DAY);
    end
    return x[4:0];
  endfunction

  // (a - b) mod 7 != 0; a, b < 32
  function automatic logic week_gap_nz(input day_t a, input day_t b);
    logic [6:0] x;
    logic       hit;
    x   = 7'(a) + 7'(5 * DAYS_PER_WEEK) - 7'(b);
    hit = 1'b0;
    for (int k = 0; k < 10; k++) begin
      if (x == 7'(k * DAYS_PER_WEEK)) begin
        hit = 1'b1;
      end
    end
    return !hit;
  endfunction

endpackage

### design/ohb_in_if.sv
// ----------------------------------------------------------------------------
// ohb_in_if
// Minute bar channel: valid/ready handshake plus one minute bar word.
// ----------------------------------------------------------------------------
interface ohb_in_if #(
  parameter int PRICE_BITS = ohb_pkg::PRICE_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  ohb_pkg::year_t          in_year;
  ohb_pkg::month_t         in_month;
  ohb_pkg::day_t           in_day;
  ohb_pkg::hour_t          in_hour;
  ohb_pkg::minute_t        in_minute;
  logic [PRICE_BITS-1:0]   open_price;
  logic [PRICE_BITS-1:0]   high_price;
  logic [PRICE_BITS-1:0]   low_price;
  logic [PRICE_BITS-1:0]   close_price;
  ohb_pkg::vol_in_t        trade_volume;
  logic                    end_of_series;

  modport source (
    output valid, in_year, in_month, in_day, in_hour, in_minute,
           open_price, high_price, low_price, close_price,
           trade_volume, end_of_series,
    input  ready
  );

  modport sink (
    input  valid, in_year, in_month, in_day, in_hour, in_minute,
           open_price, high_price, low_price, close_price,
           trade_volume, end_of_series,
    output ready
  );
endinterface

### design/ohb_out_if.sv
// ----------------------------------------------------------------------------
// ohb_out_if
// Result bar channel: valid/ready handshake plus one aggregated bar word.
// ----------------------------------------------------------------------------
interface ohb_out_if #(
  parameter int PRICE_BITS = ohb_pkg::PRICE_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  ohb_pkg::year_t          bar_year;
  ohb_pkg::month_t         bar_month;
  ohb_pkg::day_t           bar_day;
  ohb_pkg::hour_t          bar_hour;
  ohb_pkg::minute_t        bar_minute;
  logic [PRICE_BITS-1:0]   bar_open;
  logic [PRICE_BITS-1:0]   bar_high;
  logic [PRICE_BITS-1:0]   bar_low;
  logic [PRICE_BITS-1:0]   bar_close;
  ohb_pkg::vol_t           bar_volume;
  logic                    last_of_run;

  modport source (
    output valid, bar_year, bar_month, bar_day, bar_hour, bar_minute,
           bar_open, bar_high, bar_low, bar_close, bar_volume, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, bar_year, bar_month, bar_day, bar_hour, bar_minute,
           bar_open, bar_high, bar_low, bar_close, bar_volume, last_of_run,
    output ready
  );
endinterface

### design/ohlcv_bar_resampler_top.sv
// ----------------------------------------------------------------------------
// ohlcv_bar_resampler_top
// Merges one-minute OHLCV bars into hourly, two-hour, four-hour or daily bars.
// ----------------------------------------------------------------------------
// The block accepts one minute bar per clock cycle while the result queue
// has room. An accepted word is held in the input register, is judged
// against the running bar by a single rank of compare, max/min and
// saturating-add logic, and its results are written into a four-word result
// queue, whose head is offered on the result channel. Intake continues each
// cycle as long as the queue has two free slots, so the sustained rate is
// one minute bar per cycle, limited only by the result side taking one word
// per cycle: a minute bar that both closes a bar and ends the series (or a
// passthrough bar that closes a still open bar) produces two result words,
// which leave the queue one word at a time. bar_interval selects the rule:
// 2 passthrough, 3 one hour, 4 two hours, 5 four hours, 6 day; codes 0, 1
// and 7 act as passthrough. A bar also closes when the month or year
// changes, and end_of_series flushes it.
// Write bar_interval only while the block is idle. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module ohlcv_bar_resampler_top #(
  parameter int PRICE_BITS = ohb_pkg::PRICE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ohb_pkg::ADDR_W-1:0]  paddr,
  input  logic [ohb_pkg::DATA_W-1:0]  pwdata,
  output logic [ohb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // minute bars in, aggregated bars out
  ohb_in_if.sink                      in_i,
  ohb_out_if.source                   out_o
);

  localparam int RES_W = ohb_pkg::res_w(PRICE_BITS);

  typedef logic [PRICE_BITS-1:0] price_t;

  // same layout as the engine's result word
  typedef struct packed {
    ohb_pkg::stamp_t stamp;
    price_t          px_open;
    price_t          px_high;
    price_t          px_low;
    price_t          px_close;
    ohb_pkg::vol_t   vol;
    logic            last;
  } res_t;

  logic [2:0]       mode;
  logic             room;
  ohb_pkg::push_t   push;
  logic [RES_W-1:0] res0, res1, head;
  res_t             head_res;

  ohb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  ohb_engine #(
    .PRICE_BITS (PRICE_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .mode_i (mode),
    .room_i (room),
    .push_o (push),
    .res0_o (res0),
    .res1_o (res1)
  );

  ohb_res_fifo #(
    .WIDTH (RES_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (res0),
    .data1_i (res1),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (head)
  );

  // unpack the queue head onto the result channel
  assign head_res          = head;
  assign out_o.bar_year    = head_res.stamp.year;
  assign out_o.bar_month   = head_res.stamp.month;
  assign out_o.bar_day     = head_res.stamp.day;
  assign out_o.bar_hour    = head_res.stamp.hour;
  assign out_o.bar_minute  = head_res.stamp.minute;
  assign out_o.bar_open    = head_res.px_open;
  assign out_o.bar_high    = head_res.px_high;
  assign out_o.bar_low     = head_res.px_low;
  assign out_o.bar_close   = head_res.px_close;
  assign out_o.bar_volume  = head_res.vol;
  assign out_o.last_of_run = head_res.last;

endmodule

### design/ohb_cfg_regs.sv
// ----------------------------------------------------------------------------
// ohb_cfg_regs
// APB register slave holding the bar interval.
// ----------------------------------------------------------------------------
module ohb_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ohb_pkg::ADDR_W-1:0]  paddr,
  input  logic [ohb_pkg::DATA_W-1:0]  pwdata,
  output logic [ohb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [2:0]                  mode_o
);

  logic [2:0] mode_q, mode_d;
  logic       reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == ohb_pkg::REG_BAR_INTERVAL);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  assign mode_d = wr_en ? pwdata[2:0] : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ohb_pkg::MODE_PASS;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata = reg_sel ? {{(ohb_pkg::DATA_W - 3){1'b0}}, mode_q} : '0;
  assign mode_o = mode_q;

endmodule

### design/ohb_engine.sv
// ----------------------------------------------------------------------------
// ohb_engine
// Input register, running bar state and the merge/split decision.
// ----------------------------------------------------------------------------
module ohb_engine #(
  parameter int PRICE_BITS = ohb_pkg::PRICE_BITS_DEF,
  localparam int RES_W = ohb_pkg::res_w(PRICE_BITS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ohb_in_if.sink               in_i,
  input  logic [2:0]           mode_i,
  input  logic                 room_i,
  output ohb_pkg::push_t       push_o,
  output logic [RES_W-1:0]     res0_o,
  output logic [RES_W-1:0]     res1_o
);

  typedef logic [PRICE_BITS-1:0] price_t;

  typedef struct packed {
    ohb_pkg::stamp_t stamp;
    price_t          px_open;
    price_t          px_high;
    price_t          px_low;
    price_t          px_close;
    ohb_pkg::vol_t   vol;
  } bar_t;

  typedef struct packed {
    bar_t bar;
    logic last;
  } res_t;

  typedef struct packed {
    ohb_pkg::stamp_t  stamp;
    price_t           px_open;
    price_t           px_high;
    price_t           px_low;
    price_t           px_close;
    ohb_pkg::vol_in_t vol;
    logic             eos;
  } item_t;

  // input register
  logic  stage_v_q, stage_v_d;
  item_t stage_q, stage_d;
  logic  accept, proc;

  // running bar
  logic  open_q, open_d;
  bar_t  run_q, run_d;

  logic  pass, rule_hit, split;
  bar_t  in_bar, merged, next_bar;
  logic  [ohb_pkg::VOL_W:0] vol_sum;
  logic  out0_v, out1_v;
  res_t  res0, res1;

  assign proc       = stage_v_q && room_i;
  assign in_i.ready = !stage_v_q || room_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    stage_d = stage_q;
    if (accept) begin
      stage_d.stamp    = '{in_i.in_year, in_i.in_month, in_i.in_day,
                           in_i.in_hour, in_i.in_minute};
      stage_d.px_open  = in_i.open_price;
      stage_d.px_high  = in_i.high_price;
      stage_d.px_low   = in_i.low_price;
      stage_d.px_close = in_i.close_price;
      stage_d.vol      = in_i.trade_volume;
      stage_d.eos      = in_i.end_of_series;
    end
  end

  assign stage_v_d = accept ? 1'b1 : (proc ? 1'b0 : stage_v_q);

  // minute bar as a bar of its own
  always_comb begin
    in_bar.stamp    = stage_q.stamp;
    in_bar.px_open  = stage_q.px_open;
    in_bar.px_high  = stage_q.px_high;
    in_bar.px_low   = stage_q.px_low;
    in_bar.px_close = stage_q.px_close;
    in_bar.vol      = ohb_pkg::VOL_W'(stage_q.vol);
  end

  // merge into the running bar, volume saturates
  assign vol_sum = {1'b0, run_q.vol} + (ohb_pkg::VOL_W + 1)'(stage_q.vol);

  always_comb begin
    merged          = run_q;
    merged.px_high  = (stage_q.px_high > run_q.px_high) ? stage_q.px_high : run_q.px_high;
    merged.px_low   = (stage_q.px_low < run_q.px_low) ? stage_q.px_low : run_q.px_low;
    merged.px_close = stage_q.px_close;
    merged.vol      = vol_sum[ohb_pkg::VOL_W] ? '1 : vol_sum[ohb_pkg::VOL_W-1:0];
  end

  // bar boundary rules, measured from the bar's first minute
  always_comb begin
    pass     = 1'b0;
    rule_hit = 1'b0;
    unique case (mode_i)
      ohb_pkg::MODE_1H: begin
        rule_hit = (stage_q.stamp.hour != run_q.stamp.hour);
      end
      ohb_pkg::MODE_2H: begin
        rule_hit = ohb_pkg::hour_gap(stage_q.stamp.hour, run_q.stamp.hour)
                   >= ohb_pkg::SPAN_2H;
      end
      ohb_pkg::MODE_4H: begin
        rule_hit = ohb_pkg::hour_gap(stage_q.stamp.hour, run_q.stamp.hour)
                   >= ohb_pkg::SPAN_4H;
      end
      ohb_pkg::MODE_DAY: begin
        rule_hit = ohb_pkg::week_gap_nz(stage_q.stamp.day, run_q.stamp.day);
      end
      default: begin
        pass = 1'b1;
      end
    endcase
  end

  assign split = !pass && open_q &&
                 (rule_hit ||
                  (stage_q.stamp.month != run_q.stamp.month) ||
                  (stage_q.stamp.year != run_q.stamp.year));

  assign next_bar = (open_q && !split) ? merged : in_bar;

  // up to two results; the second one is always the minute bar itself
  assign out0_v = pass || split || stage_q.eos;
  assign out1_v = (pass && open_q) || (split && stage_q.eos);

  always_comb begin
    if ((pass && open_q) || split) begin
      res0.bar = run_q;
    end else if (pass) begin
      res0.bar = in_bar;
    end else begin
      res0.bar = next_bar;
    end
    res0.last = !out1_v;
    res1.bar  = in_bar;
    res1.last = 1'b1;
  end

  assign res0_o       = res0;
  assign res1_o       = res1;
  assign push_o.push0 = proc && out0_v;
  assign push_o.push1 = proc && out1_v;

  always_comb begin
    open_d = open_q;
    run_d  = run_q;
    if (proc) begin
      if (pass) begin
        open_d = 1'b0;
      end else begin
        open_d = !stage_q.eos;
        run_d  = next_bar;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
      open_q    <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
      open_q    <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
    run_q   <= run_d;
  end

endmodule

### design/ohb_res_fifo.sv
// ----------------------------------------------------------------------------
// ohb_res_fifo
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module ohb_res_fifo #(
  parameter int WIDTH = ohb_pkg::res_w(ohb_pkg::PRICE_BITS_DEF)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ohb_pkg::push_t     push_i,
  input  logic [WIDTH-1:0]   data0_i,
  input  logic [WIDTH-1:0]   data1_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [WIDTH-1:0]   data_o
);

  localparam int DEPTH = ohb_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [1:0]       n_push;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  // room for two more words
  assign room_o  = (cnt_q <= CNT_W'(DEPTH - 2));

  assign n_push = {1'b0, push_i.push0} + {1'b0, push_i.push1};
  assign wr_nxt = wr_q + PTR_W'(1);
  assign wr_d   = wr_q + PTR_W'(n_push);
  assign rd_d   = rd_q + PTR_W'(pop);
  assign cnt_d  = cnt_q + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // push1 only comes together with push0
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push_i.push1) begin
      mem_q[wr_nxt] <= data1_i;
    end
  end

endmodule

### dv/ohlcv_bar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohlcv_bar_checker
// Watches the minute bar channel, the result channel and the register port.
// Keeps its own model of the running bar, queues the bars that each accepted
// minute bar must produce, and compares every result word field by field.
// ----------------------------------------------------------------------------
module ohlcv_bar_checker #(
  parameter int PRICE_BITS = ohb_pkg::PRICE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [ohb_pkg::ADDR_W-1:0] paddr_i,
  input  logic [ohb_pkg::DATA_W-1:0] pwdata_i,
  ohb_in_if                          minute_i,
  ohb_out_if                         bar_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  import ohb_pkg::*;

  typedef logic [PRICE_BITS-1:0] price_t;

  typedef struct packed {
    stamp_t stamp;
    price_t px_open;
    price_t px_high;
    price_t px_low;
    price_t px_close;
    vol_t   volume;
    logic   last;
  } bar_word_t;

  logic [2:0] interval_q;
  logic       bar_live;
  stamp_t     first_stamp;
  price_t     acc_open, acc_high, acc_low, acc_close;
  vol_t       acc_vol;
  bar_word_t  expected_bars[$];

  // non-negative (a - b) mod m for 5-bit a, b
  function automatic int wrap_gap(input int a, input int b, input int modulus);
    return (a + 32 * modulus - b) % modulus;
  endfunction

  function automatic bar_word_t held_bar(input logic last);
    bar_word_t w;
    w.stamp    = first_stamp;
    w.px_open  = acc_open;
    w.px_high  = acc_high;
    w.px_low   = acc_low;
    w.px_close = acc_close;
    w.volume   = acc_vol;
    w.last     = last;
    return w;
  endfunction

  // append one expected bar at the tail
  task automatic enqueue_bar(input bar_word_t w);
    expected_bars.insert(expected_bars.size(), w);
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    stamp_t          ms;
    logic            split;
    logic [VOL_W:0]  vol_sum;
    bar_word_t       got, want, word;
    if (!rst_ni) begin
      interval_q  = MODE_PASS;
      bar_live    = 1'b0;
      first_stamp = '0;
      acc_open    = '0;
      acc_high    = '0;
      acc_low     = '0;
      acc_close   = '0;
      acc_vol     = '0;
      expected_bars.delete();
      pending_o   = 0;
    end else begin
      // register write; any index but the interval register is dropped
      if (psel_i && penable_i && pwrite_i && pready_i &&
          (paddr_i >> 2) == ADDR_W'(REG_BAR_INTERVAL)) begin
        interval_q = pwdata_i[2:0];
      end

      if (minute_i.valid && minute_i.ready) begin
        ms = {minute_i.in_year, minute_i.in_month, minute_i.in_day,
              minute_i.in_hour, minute_i.in_minute};
        if (interval_q < MODE_1H || interval_q > MODE_DAY) begin
          // passthrough: flush a bar left open by an earlier mode first
          if (bar_live) begin
            enqueue_bar(held_bar(1'b0));
            bar_live = 1'b0;
          end
          word.stamp    = ms;
          word.px_open  = minute_i.open_price;
          word.px_high  = minute_i.high_price;
          word.px_low   = minute_i.low_price;
          word.px_close = minute_i.close_price;
          word.volume   = vol_t'(minute_i.trade_volume);
          word.last     = 1'b1;
          enqueue_bar(word);
        end else begin
          split = 1'b0;
          if (bar_live) begin
            case (interval_q)
              MODE_1H:  split = (ms.hour != first_stamp.hour);
              MODE_2H:  split = wrap_gap(ms.hour, first_stamp.hour,
                                         HOURS_PER_DAY) >= int'(SPAN_2H);
              MODE_4H:  split = wrap_gap(ms.hour, first_stamp.hour,
                                         HOURS_PER_DAY) >= int'(SPAN_4H);
              MODE_DAY: split = wrap_gap(ms.day, first_stamp.day,
                                         DAYS_PER_WEEK) != 0;
              default: ;
            endcase
            if (ms.month != first_stamp.month || ms.year != first_stamp.year) begin
              split = 1'b1;
            end
            if (split) begin
              enqueue_bar(held_bar(!minute_i.end_of_series));
              bar_live = 1'b0;
            end
          end
          if (bar_live) begin
            if (minute_i.high_price > acc_high) acc_high = minute_i.high_price;
            if (minute_i.low_price < acc_low) acc_low = minute_i.low_price;
            acc_close = minute_i.close_price;
            vol_sum   = {1'b0, acc_vol} + (VOL_W + 1)'(minute_i.trade_volume);
            acc_vol   = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
          end else begin
            bar_live    = 1'b1;
            first_stamp = ms;
            acc_open    = minute_i.open_price;
            acc_high    = minute_i.high_price;
            acc_low     = minute_i.low_price;
            acc_close   = minute_i.close_price;
            acc_vol     = vol_t'(minute_i.trade_volume);
          end
          if (minute_i.end_of_series) begin
            enqueue_bar(held_bar(1'b1));
            bar_live = 1'b0;
          end
        end
      end

      if (bar_i.valid && bar_i.ready) begin
        got.stamp    = {bar_i.bar_year, bar_i.bar_month, bar_i.bar_day,
                        bar_i.bar_hour, bar_i.bar_minute};
        got.px_open  = bar_i.bar_open;
        got.px_high  = bar_i.bar_high;
        got.px_low   = bar_i.bar_low;
        got.px_close = bar_i.bar_close;
        got.volume   = bar_i.bar_volume;
        got.last     = bar_i.last_of_run;
        if (expected_bars.size() == 0) begin
          fail_count_o++;
          $display("%0t: result word with no bar expected, expected none, actual 0x%0h",
                   $time, got);
        end else begin
          want = expected_bars.pop_front();
          check_field("bar_year", want.stamp.year, got.stamp.year);
          check_field("bar_month", want.stamp.month, got.stamp.month);
          check_field("bar_day", want.stamp.day, got.stamp.day);
          check_field("bar_hour", want.stamp.hour, got.stamp.hour);
          check_field("bar_minute", want.stamp.minute, got.stamp.minute);
          check_field("bar_open", want.px_open, got.px_open);
          check_field("bar_high", want.px_high, got.px_high);
          check_field("bar_low", want.px_low, got.px_low);
          check_field("bar_close", want.px_close, got.px_close);
          check_field("bar_volume", want.volume, got.volume);
          check_field("last_of_run", want.last, got.last);
          checked_o++;
        end
      end
      pending_o = expected_bars.size();
    end
  end

endmodule

### dv/ohlcv_bar_resampler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohlcv_bar_resampler_top_tb
// Stimulus and verdict for the OHLCV bar resampler. A short directed run hits
// every interval code, the hour and day wrap rules, month and year breaks,
// end-of-series flushes and passthrough with a bar still open; a random run
// then plays time-ordered minute series with noise, jumps and saturating
// volume. The checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module ohlcv_bar_resampler_top_tb;
  import ohb_pkg::*;

  localparam int          PRICE_W       = PRICE_BITS_DEF;
  localparam int          CLK_PERIOD    = 10;
  localparam int          RANDOM_ITEMS  = 1800;
  // worst case ~2100 words x (longest idle gap + 2 results x longest stall), taken ~4x over
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // time for a word to pass the input register into the result queue, plus margin
  localparam int          SETTLE_CYCLES = 4;

  localparam logic [ADDR_W-1:0] BAR_INTERVAL_ADDR = ADDR_W'(4 * REG_BAR_INTERVAL);
  localparam logic [ADDR_W-1:0] SPARE_ADDR        = ADDR_W'(4);   // index 1, unmapped

  // interval codes with no own meaning; the block treats them as passthrough
  localparam logic [2:0] MODE_SPARE_0 = 3'd0;
  localparam logic [2:0] MODE_SPARE_1 = 3'd1;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  typedef struct {
    year_t              year;
    month_t             month;
    day_t               day;
    hour_t              hour;
    minute_t            minute;
    logic [PRICE_W-1:0] px_o;
    logic [PRICE_W-1:0] px_h;
    logic [PRICE_W-1:0] px_l;
    logic [PRICE_W-1:0] px_c;
    vol_in_t            vol;
    logic               eos;
  } minute_bar_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // calm stretches: neither side idles
  logic              calm = 1'b0;
  int                fail_count, pending, checked;
  int                items_sent = 0;
  int                reg_writes = 0;
  int unsigned       n_cycles = 0;

  ohb_in_if  #(.PRICE_BITS(PRICE_W)) mb_if  ();
  ohb_out_if #(.PRICE_BITS(PRICE_W)) bar_if ();

  ohlcv_bar_resampler_top #(.PRICE_BITS(PRICE_W)) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (mb_if),
    .out_o   (bar_if)
  );

  ohlcv_bar_checker #(.PRICE_BITS(PRICE_W)) chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .minute_i     (mb_if),
    .bar_i        (bar_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 94) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic minute_bar_t mk_minute(
    input year_t yr, input month_t mo, input day_t dy, input hour_t hr,
    input minute_t mi, input logic [PRICE_W-1:0] o, input logic [PRICE_W-1:0] h,
    input logic [PRICE_W-1:0] l, input logic [PRICE_W-1:0] c, input vol_in_t v,
    input logic eos);
    minute_bar_t b;
    b.year  = yr;
    b.month = mo;
    b.day   = dy;
    b.hour  = hr;
    b.minute = mi;
    b.px_o  = o;
    b.px_h  = h;
    b.px_l  = l;
    b.px_c  = c;
    b.vol   = v;
    b.eos   = eos;
    return b;
  endfunction

  // Offer one word and hold it until the block takes it. Entered and left at
  // a falling edge; valid stays high into the next word when there is no gap.
  task automatic push_minute(input minute_bar_t b);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      mb_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mb_if.in_year       <= b.year;
    mb_if.in_month      <= b.month;
    mb_if.in_day        <= b.day;
    mb_if.in_hour       <= b.hour;
    mb_if.in_minute     <= b.minute;
    mb_if.open_price    <= b.px_o;
    mb_if.high_price    <= b.px_h;
    mb_if.low_price     <= b.px_l;
    mb_if.close_price   <= b.px_c;
    mb_if.trade_volume  <= b.vol;
    mb_if.end_of_series <= b.eos;
    mb_if.valid         <= 1'b1;
    do @(posedge clk); while (!mb_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Stop sending, wait for every predicted bar, then wait out SETTLE_CYCLES so a
  // word that makes no result clears the pipeline before the block counts as idle.
  task automatic drain_results();
    mb_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Two-phase register write; pready is expected high but is still waited on.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // Result side back pressure.
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        bar_if.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        bar_if.ready <= 1'b0;
        hold = idle_len() - 1;
      end else begin
        bar_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("Timeout after %0d cycles, %0d bars still expected", n_cycles, pending);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    minute_bar_t mb, item;
    int          len, stride_max, roll, series_no, mins, random_items;
    logic [2:0]  cur_mode;
    logic        flush, heavy;
    logic [31:0] base;

    // everything known from time zero
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    mb_if.valid = 1'b0;
    mb_if.in_year = '0;
    mb_if.in_month = '0;
    mb_if.in_day = '0;
    mb_if.in_hour = '0;
    mb_if.in_minute = '0;
    mb_if.open_price = '0;
    mb_if.high_price = '0;
    mb_if.low_price = '0;
    mb_if.close_price = '0;
    mb_if.trade_volume = '0;
    mb_if.end_of_series = 1'b0;
    bar_if.ready = 1'b0;
    cur_mode = MODE_PASS;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ---------------- directed ----------------
    // Reset interval is passthrough: all-zero word, then every field at its
    // bit maximum with end_of_series set (ignored in passthrough).
    push_minute(mk_minute(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    push_minute(mk_minute('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1));

    // One hour: merge, hour break without flush, flush on its own,
    // then a break that coincides with end of series (two words).
    drain_results();
    write_reg(BAR_INTERVAL_ADDR, DATA_W'(MODE_1H));
    push_minute(mk_minute(2024, 3, 5, 10, 0, 1000000, 1005000, 995000, 1001000, 100, 1'b0));
    push_minute(mk_minute(2024, 3, 5, 10, 30, 1001000, 1010000, 990000, 1002000, 250, 1'b0));
    push_minute(mk_minute(2024, 3, 5, 11, 0, 1002000, 1003000, 1000000, 1000500, 7, 1'b0));
    push_minute(mk_minute(2024, 3, 5, 11, 5, 1000500, 1004000, 999000, 1003300, 9, 1'b1));
    push_minute(mk_minute(2024, 3, 5, 12, 0, 1003300, 1003900, 1002000, 1002500, 1, 1'b0));
    push_minute(mk_minute(2024, 3, 5, 13, 0, 1002500, 1002600, 1001000, 1001100, 2, 1'b1));
    // same hour but a new month, then a new year with a flush
    push_minute(mk_minute(2024, 3, 31, 23, 10, 5, 9, 1, 7, 3, 1'b0));
    push_minute(mk_minute(2024, 4, 1, 23, 20, 6, 8, 2, 4, 3, 1'b0));
    push_minute(mk_minute(2025, 4, 1, 23, 30, 4, 6, 3, 5, 3, 1'b1));

    // Two hours: backward hour wraps to a large gap, forward gap breaks too.
    drain_results();
    write_reg(BAR_INTERVAL_ADDR, DATA_W'(MODE_2H));
    push_minute(mk_minute(2024, 6, 10, 5, 0, 200, 300, 100, 250, 10, 1'b0));
    push_minute(mk_minute(2024, 6, 10, 4, 59, 250, 260, 240, 255, 11, 1'b0));
    push_minute(mk_minute(2024, 6, 10, 22, 0, '1, '1, 0, '1, '1, 1'b0));

    // Switch to four hours with the 22:00 bar still open: the bar carries on
    // under the new rule; 01:00 wraps to a gap of 3, 02:00 to 4.
    drain_results();
    write_reg(BAR_INTERVAL_ADDR, DATA_W'(MODE_4H));
    push_minute(mk_minute(2024, 6, 11, 1, 0, 0, 0, 0, 0, '1, 1'b0));
    push_minute(mk_minute(2024, 6, 11, 2, 0, 77, 88, 66, 80, 5, 1'b0));

    // Passthrough with a bar open: the held bar comes out ahead of the word.
    drain_results();
    write_reg(BAR_INTERVAL_ADDR, DATA_W'(MODE_PASS));
    push_minute(mk_minute(2024, 6, 11, 3, 0, 1, 2, 0, 1, 4, 1'b0));

    // Day rule: a day 28 back is 0 mod 7 and merges, the next day breaks
    // together with end of series; then out-of-range day and month alone.
    drain_results();
    write_reg(BAR_INTERVAL_ADDR, DATA_W'(MODE_DAY));
    push_minute(mk_minute(2024, 1, 30, 8, 0, 500, 600, 400, 550, 20, 1'b0));
    push_minute(mk_minute(2024, 1, 2, 9, 0, 550, 700, 300, 650, 30, 1'b0));
    push_minute(mk_minute(2024, 1, 31, 10, 0, 650, 660, 640, 645, 40, 1'b1));
    push_minute(mk_minute(4095, 0, 0, 31, 63, '1, 0, '1, 0, 0, 1'b1));

    // Unused codes act as passthrough; a write to the unmapped index is lost.
    drain_results();
    write_reg(BAR_INTERVAL_ADDR, DATA_W'(MODE_SPARE_7));
    push_minute(mk_minute(100, 2, 3, 4, 5, 6, 7, 8, 9, 10, 1'b0));
    drain_results();
    write_reg(BAR_INTERVAL_ADDR, DATA_W'(MODE_SPARE_0));
    push_minute(mk_minute(101, 2, 3, 4, 5, 6, 7, 8, 9, 10, 1'b1));
    drain_results();
    write_reg(BAR_INTERVAL_ADDR, DATA_W'(MODE_SPARE_1));
    write_reg(SPARE_ADDR, DATA_W'(MODE_1H));
    push_minute(mk_minute(102, 2, 3, 4, 5, 6, 7, 8, 9, 10, 1'b0));
    cur_mode = MODE_SPARE_1;

    // ---------------- random series ----------------
    // Each series is a time-ordered run of minutes from a random start, with
    // a stride suited to the interval, a little noise and a few jumps. Most
    // end with a flush; the rest leave a bar open for the next series.
    // The third series holds a 270-minute day bar of maximum volumes to saturate.
    random_items = 0;
    series_no    = 0;
    while (random_items < RANDOM_ITEMS) begin
      heavy = (series_no == 2);
      drain_results();
      if ($urandom_range(0, 5) == 0) begin
        write_reg(SPARE_ADDR, DATA_W'($urandom));
      end
      if (heavy || $urandom_range(0, 4) != 0) begin
        if (heavy) begin
          cur_mode = MODE_DAY;
        end else begin
          roll = $urandom_range(0, 9);
          if (roll == 0) begin
            case ($urandom_range(0, 2))
              0:       cur_mode = MODE_SPARE_0;
              1:       cur_mode = MODE_SPARE_1;
              default: cur_mode = MODE_SPARE_7;
            endcase
          end else if (roll == 1) begin
            cur_mode = MODE_PASS;
          end else begin
            case ($urandom_range(0, 3))
              0:       cur_mode = MODE_1H;
              1:       cur_mode = MODE_2H;
              2:       cur_mode = MODE_4H;
              default: cur_mode = MODE_DAY;
            endcase
          end
        end
        // upper data bits are don't-care; exercise them half the time
        write_reg(BAR_INTERVAL_ADDR,
                  ($urandom_range(0, 1) == 0) ? DATA_W'(cur_mode)
                                              : {29'($urandom), cur_mode});
      end

      calm  = heavy || ($urandom_range(0, 3) == 0);
      len   = heavy ? 270 : $urandom_range(3, 80);
      flush = heavy || ($urandom_range(0, 9) < 7);
      case (cur_mode)
        MODE_1H:  stride_max = 20;
        MODE_2H:  stride_max = 60;
        MODE_4H:  stride_max = 120;
        MODE_DAY: stride_max = 480;
        default:  stride_max = 30;
      endcase

      mb.year   = year_t'($urandom);
      mb.month  = month_t'($urandom_range(1, 12));
      mb.day    = day_t'($urandom_range(1, 28));
      mb.hour   = heavy ? hour_t'(0) : hour_t'($urandom_range(0, 23));
      mb.minute = heavy ? minute_t'(0) : minute_t'($urandom_range(0, 59));
      base      = $urandom;

      for (int k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        if (k > 0) begin
          // advance the series clock with hour, day, month and year carries
          mins = int'(mb.minute) + (heavy ? 1 : $urandom_range(0, stride_max));
          while (mins >= 60) begin
            mins -= 60;
            if (mb.hour >= 23) begin
              mb.hour = '0;
              if (mb.day >= 30) begin
                mb.day = 5'd1;
                if (mb.month >= 12) begin
                  mb.month = 4'd1;
                  mb.year++;
                end else begin
                  mb.month++;
                end
              end else begin
                mb.day++;
              end
            end else begin
              mb.hour++;
            end
          end
          mb.minute = minute_t'(mins);
        end
        if (!heavy && roll >= 4 && roll < 8) begin
          // jump: the clock goes back or ahead, sometimes to another month
          mb.hour = hour_t'($urandom_range(0, 23));
          mb.day  = day_t'($urandom_range(1, 28));
          if (roll == 7) mb.month = month_t'($urandom_range(1, 12));
        end
        item = mb;
        if (!heavy && roll < 4) begin
          // noise: any bit pattern in the stamp, the series clock is kept
          item.year   = year_t'($urandom);
          item.month  = month_t'($urandom);
          item.day    = day_t'($urandom);
          item.hour   = hour_t'($urandom);
          item.minute = minute_t'($urandom);
        end
        if ($urandom_range(0, 3) == 0) begin
          item.px_o = $urandom;
          item.px_h = $urandom;
          item.px_l = $urandom;
          item.px_c = $urandom;
        end else begin
          base      = base + $urandom_range(0, 400) - 200;
          item.px_o = base;
          item.px_h = base + $urandom_range(0, 300);
          item.px_l = base - $urandom_range(0, 300);
          item.px_c = base + $urandom_range(0, 300) - 150;
        end
        roll = $urandom_range(0, 9);
        if (heavy || roll == 1) begin
          item.vol = '1;
        end else if (roll == 0) begin
          item.vol = {8'($urandom), 32'($urandom)};
        end else begin
          item.vol = vol_in_t'($urandom_range(0, 50000));
        end
        item.eos = (k == len - 1) ? flush : ($urandom_range(0, 49) == 0);
        push_minute(item);
        random_items++;
      end
      series_no++;
    end

    // ---------------- wrap up ----------------
    calm = 1'b0;
    drain_results();
    repeat (10) @(negedge clk);
    $display("Run covered %0d minute bars in %0d series, %0d register writes, %0d bars checked",
             items_sent, series_no, reg_writes, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d bars never arrived", fail_count, pending);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
